@@ hdl/tcrp_pkg.sv @@
// Shared types and constants for the tree/commit record parser.
`timescale 1ns / 1ps

package tcrp_pkg;

  // Default width of an object id in bytes
  localparam int ID_BYTES_DEF = 32;

  // Field kind codes carried on each result item
  localparam logic [3:0] KIND_COUNT     = 4'd0;
  localparam logic [3:0] KIND_NAMELEN   = 4'd1;
  localparam logic [3:0] KIND_NAME      = 4'd2;
  localparam logic [3:0] KIND_DIRFLAG   = 4'd3;
  localparam logic [3:0] KIND_ENTRY_ID  = 4'd4;
  localparam logic [3:0] KIND_TREE_ID   = 4'd5;
  localparam logic [3:0] KIND_PCOUNT    = 4'd6;
  localparam logic [3:0] KIND_PARENT_ID = 4'd7;
  localparam logic [3:0] KIND_AUTHLEN   = 4'd8;
  localparam logic [3:0] KIND_AUTHOR    = 4'd9;
  localparam logic [3:0] KIND_MSGLEN    = 4'd10;
  localparam logic [3:0] KIND_MSG       = 4'd11;
  localparam logic [3:0] KIND_EXCESS    = 4'd12;

  // Status codes reported on the last byte
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TRUNC    = 2'd1;
  localparam logic [1:0] ST_TRAILING = 2'd2;

  // Format mode register values
  localparam logic MODE_TREE   = 1'b0;
  localparam logic MODE_COMMIT = 1'b1;

  // Width of the big-endian length and count fields in bytes
  localparam logic [31:0] LEN_BYTES = 32'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  field_kind;
    logic [31:0] entry_index;
    logic        done_res;
    logic [1:0]  status;
  } out_item_t;

endpackage

@@ hdl/tcrp_core.sv @@
// Parse state machine: tags one body byte per step and tracks record structure.
`timescale 1ns / 1ps

module tcrp_core #(
  parameter int ID_BYTES = tcrp_pkg::ID_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                step,
  input  tcrp_pkg::in_item_t  item,
  output tcrp_pkg::out_item_t result
);

  import tcrp_pkg::*;

  localparam logic [31:0] IdLen = 32'(ID_BYTES);

  typedef enum logic [3:0] {
    PH_COUNT   = 4'd0,
    PH_NAMELEN = 4'd1,
    PH_NAME    = 4'd2,
    PH_DIR     = 4'd3,
    PH_EID     = 4'd4,
    PH_TREEID  = 4'd5,
    PH_PCOUNT  = 4'd6,
    PH_PARENT  = 4'd7,
    PH_AUTHLEN = 4'd8,
    PH_AUTH    = 4'd9,
    PH_MSGLEN  = 4'd10,
    PH_MSG     = 4'd11,
    PH_DONE    = 4'd12,
    PH_EXCESS  = 4'd13
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        mode_r, mode_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] items_r, items_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic        complete_r, complete_nxt;

  logic        do_restart;
  logic        rs_mode;
  logic        in_list;
  logic        is_len;
  logic [31:0] acc_upd;
  logic [31:0] left_dec;
  logic [31:0] items_dec;
  logic [3:0]  kind;
  logic [31:0] eidx;
  logic [1:0]  status;

  // Next-state logic for one byte, plus restart on last byte or mode write
  always_comb begin
    phase_nxt    = phase_r;
    mode_nxt     = mode_r;
    left_nxt     = left_r;
    acc_nxt      = acc_r;
    items_nxt    = items_r;
    idx_nxt      = idx_r;
    complete_nxt = complete_r;
    do_restart   = 1'b0;
    rs_mode      = mode_r;
    kind         = KIND_EXCESS;
    eidx         = '0;
    status       = ST_OK;
    in_list      = (phase_r == PH_NAMELEN) || (phase_r == PH_NAME) || (phase_r == PH_DIR) ||
                   (phase_r == PH_EID) || (phase_r == PH_PARENT);
    is_len       = (phase_r == PH_COUNT) || (phase_r == PH_NAMELEN) ||
                   (phase_r == PH_PCOUNT) || (phase_r == PH_AUTHLEN) ||
                   (phase_r == PH_MSGLEN);
    acc_upd      = is_len ? {acc_r[23:0], item.data_byte} : acc_r;
    left_dec     = (left_r == '0) ? '0 : left_r - 32'd1;
    items_dec    = items_r - 32'd1;

    // Field kind of the current byte
    unique case (phase_r)
      PH_COUNT:   kind = KIND_COUNT;
      PH_NAMELEN: kind = KIND_NAMELEN;
      PH_NAME:    kind = KIND_NAME;
      PH_DIR:     kind = KIND_DIRFLAG;
      PH_EID:     kind = KIND_ENTRY_ID;
      PH_TREEID:  kind = KIND_TREE_ID;
      PH_PCOUNT:  kind = KIND_PCOUNT;
      PH_PARENT:  kind = KIND_PARENT_ID;
      PH_AUTHLEN: kind = KIND_AUTHLEN;
      PH_AUTH:    kind = KIND_AUTHOR;
      PH_MSGLEN:  kind = KIND_MSGLEN;
      PH_MSG:     kind = KIND_MSG;
      default:    kind = KIND_EXCESS;
    endcase

    if (step) begin
      if (phase_r == PH_DONE || phase_r == PH_EXCESS) begin
        phase_nxt = PH_EXCESS;
      end else begin
        if (in_list) begin
          eidx = idx_r;
        end
        if (left_dec != '0) begin
          left_nxt = left_dec;
          acc_nxt  = acc_upd;
        end else begin
          // Field finished: pick the next field from the decoded value
          acc_nxt = '0;
          unique case (phase_r)
            PH_COUNT: begin
              items_nxt = acc_upd;
              idx_nxt   = '0;
              if (acc_upd == '0) begin
                phase_nxt = PH_DONE; left_nxt = '0; complete_nxt = 1'b1;
              end else begin
                phase_nxt = PH_NAMELEN; left_nxt = LEN_BYTES;
              end
            end
            PH_NAMELEN: begin
              if (acc_upd == '0) begin
                phase_nxt = PH_DIR; left_nxt = 32'd1;
              end else begin
                phase_nxt = PH_NAME; left_nxt = acc_upd;
              end
            end
            PH_NAME: begin
              phase_nxt = PH_DIR; left_nxt = 32'd1;
            end
            PH_DIR: begin
              phase_nxt = PH_EID; left_nxt = IdLen;
            end
            PH_EID: begin
              items_nxt = items_dec;
              idx_nxt   = idx_r + 32'd1;
              if (items_dec == '0) begin
                phase_nxt = PH_DONE; left_nxt = '0; complete_nxt = 1'b1;
              end else begin
                phase_nxt = PH_NAMELEN; left_nxt = LEN_BYTES;
              end
            end
            PH_TREEID: begin
              phase_nxt = PH_PCOUNT; left_nxt = LEN_BYTES;
            end
            PH_PCOUNT: begin
              items_nxt = acc_upd;
              idx_nxt   = '0;
              if (acc_upd == '0) begin
                phase_nxt = PH_AUTHLEN; left_nxt = LEN_BYTES;
              end else begin
                phase_nxt = PH_PARENT; left_nxt = IdLen;
              end
            end
            PH_PARENT: begin
              items_nxt = items_dec;
              idx_nxt   = idx_r + 32'd1;
              if (items_dec == '0) begin
                phase_nxt = PH_AUTHLEN; left_nxt = LEN_BYTES;
              end else begin
                phase_nxt = PH_PARENT; left_nxt = IdLen;
              end
            end
            PH_AUTHLEN: begin
              if (acc_upd == '0) begin
                phase_nxt = PH_MSGLEN; left_nxt = LEN_BYTES;
              end else begin
                phase_nxt = PH_AUTH; left_nxt = acc_upd;
              end
            end
            PH_AUTH: begin
              phase_nxt = PH_MSGLEN; left_nxt = LEN_BYTES;
            end
            PH_MSGLEN: begin
              if (acc_upd == '0) begin
                phase_nxt = PH_DONE; left_nxt = '0; complete_nxt = 1'b1;
              end else begin
                phase_nxt = PH_MSG; left_nxt = acc_upd;
              end
            end
            default: begin
              phase_nxt = PH_DONE; left_nxt = '0; complete_nxt = 1'b1;
            end
          endcase
        end
      end

      // Status on the last byte, then start over for the next body
      if (item.last) begin
        if (phase_nxt == PH_EXCESS) begin
          status = ST_TRAILING;
        end else if (complete_nxt) begin
          status = ST_OK;
        end else begin
          status = ST_TRUNC;
        end
        do_restart = 1'b1;
      end
    end

    // A mode write restarts the parse in the new format
    if (cfg_we) begin
      mode_nxt   = cfg_wdata;
      rs_mode    = cfg_wdata;
      do_restart = 1'b1;
    end

    if (do_restart) begin
      phase_nxt    = (rs_mode == MODE_COMMIT) ? PH_TREEID : PH_COUNT;
      left_nxt     = (rs_mode == MODE_COMMIT) ? IdLen : LEN_BYTES;
      acc_nxt      = '0;
      items_nxt    = '0;
      idx_nxt      = '0;
      complete_nxt = 1'b0;
    end
  end

  // Result of the current step
  always_comb begin
    result.byte_out    = item.data_byte;
    result.field_kind  = kind;
    result.entry_index = eidx;
    result.done_res    = item.last;
    result.status      = status;
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_COUNT;
      mode_r     <= MODE_TREE;
      left_r     <= LEN_BYTES;
      acc_r      <= '0;
      items_r    <= '0;
      idx_r      <= '0;
      complete_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      mode_r     <= mode_nxt;
      left_r     <= left_nxt;
      acc_r      <= acc_nxt;
      items_r    <= items_nxt;
      idx_r      <= idx_nxt;
      complete_r <= complete_nxt;
    end
  end

`ifndef SYNTHESIS
  // Structure complete only once the parse reached its end phases
  a_complete_phase: assert property (@(posedge clk) disable iff (!rst_n)
    complete_r |-> (phase_r == PH_DONE || phase_r == PH_EXCESS))
    else $error("structure complete outside end phases");

  // Every active field still has bytes to receive
  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !(phase_r == PH_DONE || phase_r == PH_EXCESS) |-> (left_r != '0))
    else $error("active field with no bytes left");

  // Mode write restarts the parse
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (idx_r == '0 && !complete_r && acc_r == '0))
    else $error("mode write did not restart parse");

  // Status stays zero on results that are not the last byte
  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !item.last) |-> (result.status == ST_OK))
    else $error("status set on non-last byte");
`endif

endmodule

@@ hdl/tree_commit_record_parser.sv @@
// An item is accepted into the input register, and its result is registered in
// the result register once that register is free. Throughput: 1 item per cycle
// unless out_ready stalls the result register; every byte takes one pass through
// the phase machine, whose counters and 32-bit compares set the cycle.
// Reset (rst_n low, synchronous): both stages empty, tree format selected,
// parse at the start of a body.
`timescale 1ns / 1ps

module tree_commit_record_parser #(
  parameter int ID_BYTES = tcrp_pkg::ID_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcrp_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tcrp_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  import tcrp_pkg::*;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      step;
  out_item_t result;

  // Item in the input register moves when the result register is free
  assign step     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || step;

  tcrp_core #(
    .ID_BYTES (ID_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (s1_item_r),
    .result    (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
